### rtl/core/button_gesture_classifier_macros.svh
// Assertion macros shared by the button gesture classifier checkers.
// Needs a clk and an active-high rst signal in the including scope.
`ifndef BUTTON_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define BGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define BGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/bgc_pkg.sv
// Shared widths, gesture codes and register indexes of the button gesture classifier.
// No dependencies; imported by the top level and its checker.
package bgc_pkg;

  localparam int CNT_W  = 16;                       // elapsed and confirm counter width
  localparam int CFG_W  = 16;                       // configuration register width
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int IDX_W  = 3;                        // configuration index width
  localparam int CLK_W  = 3;                        // click counter width
  localparam int GEST_W = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [CLK_W-1:0] CLK_MAX  = {CLK_W{1'b1}};
  localparam logic [CLK_W-1:0] CLK_FIVE = CLK_W'(5);
  localparam logic [CLK_W-1:0] CLK_TWO  = CLK_W'(2);
  localparam logic [CLK_W-1:0] CLK_ONE  = CLK_W'(1);

  typedef enum logic [GEST_W-1:0] {
    GEST_SHORT     = 3'd0,
    GEST_DOUBLE    = 3'd1,
    GEST_FIVE      = 3'd2,
    GEST_ACTIVATE  = 3'd3,
    GEST_PROVISION = 3'd4,
    GEST_FACTORY   = 3'd5
  } gesture_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FACTORY   = 3'd0,
    REG_PROVISION = 3'd1,
    REG_ACTIVATE  = 3'd2,
    REG_DEBOUNCE  = 3'd3,
    REG_WINDOW    = 3'd4
  } reg_idx_t;

  localparam logic [CFG_W-1:0] FACTORY_RST   = CFG_W'(15000);
  localparam logic [CFG_W-1:0] PROVISION_RST = CFG_W'(10000);
  localparam logic [CFG_W-1:0] ACTIVATE_RST  = CFG_W'(5000);
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = CFG_W'(50);
  localparam logic [CFG_W-1:0] WINDOW_RST    = CFG_W'(450);

endpackage

### rtl/core/button_gesture_classifier.sv
// Button gesture classifier top level: hold timing, multi-click counting, result register.
// Depends on bgc_pkg for widths, gesture codes and register indexes.
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+---------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata[0] button_pressed
//  m_axis    | out | m_axis_tvalid/m_axis_tready | tdata[2:0] gesture
//  cfg       | in  | cfg_we (no wait)            | cfg_index, cfg_data[15:0]
//
// One sample beat per cycle unless stalled; each gives zero or one gesture beat next cycle.
// The whole update of phase and counters is one combinational pass into the state registers.
// s_axis_tready is high whenever the result register is empty or being drained this cycle.
// rst is synchronous: phase idle, counters zero, registers at their defaults, no result.
// A stalled result holds m_axis_tdata steady and blocks sample beats until it is taken.
module button_gesture_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bgc_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [0] button_pressed, rest zero
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bgc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [2:0] gesture, rest zero
  input  logic                           cfg_we,
  input  logic [bgc_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bgc_pkg::CFG_W-1:0]      cfg_data
);
  import bgc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HOLD      = 3'd1,
    PH_WINDOW    = 3'd2,
    PH_CONFIRM   = 3'd3,
    PH_CLICKHELD = 3'd4
  } phase_t;

  // Configuration registers.
  logic [CFG_W-1:0] factory_hold;
  logic [CFG_W-1:0] provision_hold;
  logic [CFG_W-1:0] activate_hold;
  logic [CFG_W-1:0] debounce;
  logic [CFG_W-1:0] click_window;

  // Gesture state.
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] elapsed, elapsed_next;
  logic [CNT_W-1:0] confirm, confirm_next;
  logic [CLK_W-1:0] clicks, clicks_next;

  // Result register.
  logic             out_valid;
  gesture_t         gesture;
  logic             emit;
  gesture_t         emit_gesture;

  logic             accept;
  logic             pressed;
  logic [CNT_W-1:0] elapsed_inc;
  logic [CNT_W-1:0] confirm_inc;
  logic [CLK_W-1:0] clicks_inc;
  logic [CMP_W-1:0] elapsed_cmp;
  logic [CMP_W-1:0] confirm_inc_cmp;

  // Take a new sample whenever the result register is free or drains this cycle.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pressed       = s_axis_tdata[0];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - GEST_W)'(0), gesture};

  // Saturating increments.
  assign elapsed_inc = (elapsed == CNT_MAX) ? CNT_MAX : elapsed + 1'b1;
  assign confirm_inc = (confirm == CNT_MAX) ? CNT_MAX : confirm + 1'b1;
  assign clicks_inc  = (clicks == CLK_MAX) ? CLK_MAX : clicks + 1'b1;

  assign elapsed_cmp     = CMP_W'(elapsed);
  assign confirm_inc_cmp = CMP_W'(confirm_inc);

  always_comb begin
    phase_next   = phase;
    elapsed_next = elapsed;
    confirm_next = confirm;
    clicks_next  = clicks;
    emit         = 1'b0;
    emit_gesture = GEST_SHORT;
    unique case (phase)
      PH_HOLD: begin
        if (pressed) begin
          elapsed_next = elapsed_inc;
        end else begin
          // Release: longest threshold wins, then open the window, else drop noise.
          phase_next = PH_IDLE;
          if (elapsed_cmp >= CMP_W'(factory_hold)) begin
            emit         = 1'b1;
            emit_gesture = GEST_FACTORY;
          end else if (elapsed_cmp >= CMP_W'(provision_hold)) begin
            emit         = 1'b1;
            emit_gesture = GEST_PROVISION;
          end else if (elapsed_cmp >= CMP_W'(activate_hold)) begin
            emit         = 1'b1;
            emit_gesture = GEST_ACTIVATE;
          end else if (elapsed_cmp >= CMP_W'(debounce)) begin
            phase_next   = PH_WINDOW;
            clicks_next  = CLK_ONE;
            elapsed_next = '0;
          end
        end
      end
      PH_WINDOW: begin
        if (elapsed_cmp >= CMP_W'(click_window)) begin
          // Window ran out: the sample of this beat is ignored.
          phase_next   = PH_IDLE;
          emit         = 1'b1;
          emit_gesture = (clicks == CLK_TWO) ? GEST_DOUBLE : GEST_SHORT;
        end else begin
          elapsed_next = elapsed_inc;
          if (pressed) begin
            confirm_next = '0;
            if (debounce == '0) begin
              clicks_next = clicks_inc;
              phase_next  = PH_CLICKHELD;
            end else begin
              phase_next = PH_CONFIRM;
            end
          end
        end
      end
      PH_CONFIRM: begin
        // Window timer keeps running while the new press is confirmed.
        elapsed_next = elapsed_inc;
        confirm_next = confirm_inc;
        if (confirm_inc_cmp >= CMP_W'(debounce)) begin
          if (pressed) begin
            clicks_next = clicks_inc;
            phase_next  = PH_CLICKHELD;
          end else begin
            phase_next = PH_WINDOW;
          end
        end
      end
      PH_CLICKHELD: begin
        if (!pressed) begin
          elapsed_next = '0;
          if (clicks >= CLK_FIVE) begin
            phase_next   = PH_IDLE;
            emit         = 1'b1;
            emit_gesture = GEST_FIVE;
          end else begin
            phase_next = PH_WINDOW;
          end
        end
      end
      default: begin
        // Idle and any unused code behave as idle.
        phase_next = PH_IDLE;
        if (pressed) begin
          phase_next   = PH_HOLD;
          elapsed_next = CNT_W'(1);
          confirm_next = '0;
          clicks_next  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      factory_hold   <= FACTORY_RST;
      provision_hold <= PROVISION_RST;
      activate_hold  <= ACTIVATE_RST;
      debounce       <= DEBOUNCE_RST;
      click_window   <= WINDOW_RST;
      phase          <= PH_IDLE;
      elapsed        <= '0;
      confirm        <= '0;
      clicks         <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FACTORY:   factory_hold   <= cfg_data;
          REG_PROVISION: provision_hold <= cfg_data;
          REG_ACTIVATE:  activate_hold  <= cfg_data;
          REG_DEBOUNCE:  debounce       <= cfg_data;
          REG_WINDOW:    click_window   <= cfg_data;
          default: ;
        endcase
      end
      // Advance the gesture state on each accepted sample beat.
      if (accept) begin
        phase   <= phase_next;
        elapsed <= elapsed_next;
        confirm <= confirm_next;
        clicks  <= clicks_next;
      end
      // Load a new result or drop the one just taken.
      if (accept && emit) begin
        out_valid <= 1'b1;
        gesture   <= emit_gesture;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/bgc_checker.sv
// Port-level checker for the button gesture classifier, bound to the top level.
// Depends on bgc_pkg and button_gesture_classifier_macros.svh.
`include "button_gesture_classifier_macros.svh"

module bgc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bgc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bgc_pkg::*;

  logic out_stall;
  logic s_beat;
  logic gesture_ok;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign s_beat     = s_axis_tvalid && s_axis_tready;
  assign gesture_ok = (m_axis_tdata[GEST_W-1:0] <= GEST_FACTORY) &&
                      (m_axis_tdata[OUT_TDATA_W-1:GEST_W] == '0);

  // A stalled result beat holds its payload.
  `BGC_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result moved")

  // An empty result register never stalls the sample side.
  `BGC_ASSERT_ALWAYS(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "empty but stalled")

  // A result appears only after an accepted sample beat.
  `BGC_ASSERT(a_no_spurious, !m_axis_tvalid && !s_beat |=> !m_axis_tvalid, "result without beat")

  // Gesture code in range, padding bits zero.
  `BGC_ASSERT(a_gesture_range, m_axis_tvalid |-> gesture_ok, "bad gesture beat")

  // No result right after reset.
  `BGC_ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> !m_axis_tvalid, "result valid after reset")

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);

### sim/tb.sv
// Self-checking bench for button_gesture_classifier: scripted and random button samples.
// Gestures are checked against a cycle-free classifier kept in this file.
// Depends on bgc_pkg and the button_gesture_classifier RTL only.
module tb;
  import bgc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int SCRIPT_LEN = 56;
  localparam int RANDOM_PHASES = 6;
  localparam int unsigned TICKS_PER_PHASE = 120;
  localparam int SQUEEZE_CYCLES = 300;

  // Classifier phases, one per branch of the gesture state machine.
  typedef enum logic [2:0] {
    BTN_IDLE      = 3'd0,
    BTN_HOLD      = 3'd1,
    BTN_WINDOW    = 3'd2,
    BTN_CONFIRM   = 3'd3,
    BTN_CLICKHELD = 3'd4
  } btn_state_t;

  // Script rows: either a run of identical samples or one register write.
  typedef enum bit {ROW_RUN, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;     // register for ROW_WRITE
    int unsigned amount;  // sample count for ROW_RUN, register value for ROW_WRITE
    bit          level;   // button level for ROW_RUN
    bit          typed;   // last sample of the run carries the gesture below
    gesture_t    g;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Register copies and classifier state used for prediction.
  logic [CFG_W-1:0] hold_factory = FACTORY_RST;
  logic [CFG_W-1:0] hold_provision = PROVISION_RST;
  logic [CFG_W-1:0] hold_activate = ACTIVATE_RST;
  logic [CFG_W-1:0] debounce = DEBOUNCE_RST;
  logic [CFG_W-1:0] click_window = WINDOW_RST;
  btn_state_t btn_state = BTN_IDLE;
  logic [CNT_W-1:0] elapsed = '0;
  logic [CNT_W-1:0] confirm = '0;
  logic [CLK_W-1:0] clicks = '0;

  gesture_t gesture_due[$];   // gestures owed by the block, oldest first
  int mismatch_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;  // chance per beat of an idle burst, both sides
  bit squeeze_req = 1'b0;     // set once by the stimulus to ask for the long hold-off
  bit squeeze_done = 1'b0;
  int stall_left = 0;

  // Directed script. Gestures are typed in only where they are obvious:
  // reset defaults, plain holds, double and five clicks, and the register extremes.
  script_row_t script [SCRIPT_LEN] = '{
    // reset defaults: a press one tick short of debounce is dropped,
    // a press of exactly debounce length times out as a short press
    '{ROW_RUN,   REG_FACTORY,   49,    1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   3,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   50,    1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   452,   1'b0, 1'b1, GEST_SHORT},
    // shrink everything so that each gesture takes a few dozen ticks
    '{ROW_WRITE, REG_FACTORY,   40,    1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_PROVISION, 30,    1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_ACTIVATE,  20,    1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_DEBOUNCE,  3,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_WINDOW,    10,    1'b0, 1'b0, GEST_SHORT},
    // holds right at each threshold
    '{ROW_RUN,   REG_FACTORY,   40,    1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b0, 1'b1, GEST_FACTORY},
    '{ROW_RUN,   REG_FACTORY,   30,    1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b0, 1'b1, GEST_PROVISION},
    '{ROW_RUN,   REG_FACTORY,   20,    1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b0, 1'b1, GEST_ACTIVATE},
    // just below activate: one click, then the window runs out
    '{ROW_RUN,   REG_FACTORY,   19,    1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   12,    1'b0, 1'b1, GEST_SHORT},
    // noise shorter than debounce
    '{ROW_RUN,   REG_FACTORY,   2,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   2,     1'b0, 1'b0, GEST_SHORT},
    // double press
    '{ROW_RUN,   REG_FACTORY,   5,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   3,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   5,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   12,    1'b0, 1'b1, GEST_DOUBLE},
    // second press bounces off before it is confirmed
    '{ROW_RUN,   REG_FACTORY,   5,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   2,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   2,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   12,    1'b0, 1'b0, GEST_SHORT},
    // five clicks, released on the fifth
    '{ROW_RUN,   REG_FACTORY,   5,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   2,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   5,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   2,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   5,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   2,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   5,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   2,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   5,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b0, 1'b1, GEST_FIVE},
    // zero debounce: a new press counts on its first tick
    '{ROW_WRITE, REG_DEBOUNCE,  0,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   12,    1'b0, 1'b0, GEST_SHORT},
    // smallest window and factory threshold
    '{ROW_WRITE, REG_WINDOW,    1,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_FACTORY,   1,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   1,     1'b0, 1'b1, GEST_FACTORY},
    // largest thresholds: a largest debounce drops the press as noise
    '{ROW_WRITE, REG_FACTORY,   65535, 1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_PROVISION, 65535, 1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_ACTIVATE,  65535, 1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_DEBOUNCE,  65535, 1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   30,    1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   3,     1'b0, 1'b0, GEST_SHORT},
    // then the same hold is a single click that times out
    '{ROW_WRITE, REG_DEBOUNCE,  1,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_WRITE, REG_WINDOW,    3,     1'b0, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   30,    1'b1, 1'b0, GEST_SHORT},
    '{ROW_RUN,   REG_FACTORY,   5,     1'b0, 1'b1, GEST_SHORT}
  };

  button_gesture_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] button_pressed, rest zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [2:0] gesture, rest zero
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count a confirmed click; the count stops at its top value.
  function void note_click();
    if (clicks != CLK_MAX) clicks++;
    btn_state = BTN_CLICKHELD;
  endfunction

  // Advance the classifier by one sample; fire marks a gesture on this tick.
  function void classify_tick(input bit pressed, output bit fire, output gesture_t g);
    fire = 1'b0;
    g = GEST_SHORT;
    case (btn_state)
      BTN_HOLD: begin
        if (pressed) begin
          if (elapsed != CNT_MAX) elapsed++;
        end else begin
          btn_state = BTN_IDLE;
          if (elapsed >= hold_factory) begin
            fire = 1'b1;
            g = GEST_FACTORY;
          end else if (elapsed >= hold_provision) begin
            fire = 1'b1;
            g = GEST_PROVISION;
          end else if (elapsed >= hold_activate) begin
            fire = 1'b1;
            g = GEST_ACTIVATE;
          end else if (elapsed >= debounce) begin
            // a real short press: open the click window
            btn_state = BTN_WINDOW;
            clicks = CLK_ONE;
            elapsed = '0;
          end
        end
      end
      BTN_WINDOW: begin
        if (elapsed >= click_window) begin
          // window ran out: the sample of this tick is dropped
          btn_state = BTN_IDLE;
          fire = 1'b1;
          g = (clicks == CLK_TWO) ? GEST_DOUBLE : GEST_SHORT;
        end else begin
          if (elapsed != CNT_MAX) elapsed++;
          if (pressed) begin
            confirm = '0;
            if (debounce == '0) note_click();
            else btn_state = BTN_CONFIRM;
          end
        end
      end
      BTN_CONFIRM: begin
        // window timer keeps running while the press is confirmed
        if (elapsed != CNT_MAX) elapsed++;
        if (confirm != CNT_MAX) confirm++;
        if (confirm >= debounce) begin
          if (pressed) note_click();
          else btn_state = BTN_WINDOW;
        end
      end
      BTN_CLICKHELD: begin
        if (!pressed) begin
          elapsed = '0;
          if (clicks >= CLK_FIVE) begin
            btn_state = BTN_IDLE;
            fire = 1'b1;
            g = GEST_FIVE;
          end else begin
            btn_state = BTN_WINDOW;
          end
        end
      end
      default: begin
        btn_state = BTN_IDLE;
        if (pressed) begin
          btn_state = BTN_HOLD;
          elapsed = CNT_W'(1);
          confirm = '0;
          clicks = '0;
        end
      end
    endcase
  endfunction

  // Offer one sample beat, wait for it to be taken, then predict from it.
  // typed overrides the prediction for this beat with a gesture from the script.
  task automatic send_sample(input bit level, input bit typed, input gesture_t typed_g);
    bit fire;
    gesture_t g;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, level};
    do @(posedge clk); while (!s_axis_tready);
    classify_tick(level, fire, g);
    if (typed) gesture_due.push_back(typed_g);
    else if (fire) gesture_due.push_back(g);
    ticks_sent++;
  endtask

  // Send count beats of one level; typed applies to the last beat only.
  task automatic run_level(input bit level, input int unsigned count, input bit typed,
                           input gesture_t typed_g);
    for (int unsigned i = 0; i < count; i++)
      send_sample(level, typed && (i == count - 1), typed_g);
  endtask

  // Stop offering, let every owed gesture come out, then let the block settle.
  task automatic finish_pending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (gesture_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; cfg_we drops again before the task returns to keep writes apart.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FACTORY:   hold_factory = value;
      REG_PROVISION: hold_provision = value;
      REG_ACTIVATE:  hold_activate = value;
      REG_DEBOUNCE:  debounce = value;
      REG_WINDOW:    click_window = value;
      default: ;
    endcase
  endtask

  // One random gesture, mostly well formed, sized by the current registers.
  task automatic play_random_gesture();
    int unsigned kind;
    int unsigned clicks_wanted;
    int unsigned press_len;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      // long hold anywhere from noise to past the factory threshold
      run_level(1'b1, $urandom_range(1, hold_factory + 5), 1'b0, GEST_SHORT);
      run_level(1'b0, $urandom_range(1, click_window + 4), 1'b0, GEST_SHORT);
    end else if (kind <= 6) begin
      // click train: gaps mostly inside the window, presses mostly confirmed
      clicks_wanted = $urandom_range(2, 6);
      run_level(1'b1, $urandom_range((debounce > 0) ? debounce : 1, debounce + 6),
                1'b0, GEST_SHORT);
      repeat (clicks_wanted - 1) begin
        run_level(1'b0, $urandom_range(1, click_window), 1'b0, GEST_SHORT);
        if ($urandom_range(0, 3) == 0) press_len = $urandom_range(1, debounce + 1);
        else press_len = $urandom_range(debounce + 1, debounce + 5);
        run_level(1'b1, press_len, 1'b0, GEST_SHORT);
      end
      run_level(1'b0, $urandom_range(1, click_window + 4), 1'b0, GEST_SHORT);
    end else if (kind <= 8) begin
      // raw chatter
      repeat ($urandom_range(1, 10))
        run_level(1'($urandom_range(0, 1)), 1, 1'b0, GEST_SHORT);
    end else begin
      run_level(1'b0, $urandom_range(1, click_window + 6), 1'b0, GEST_SHORT);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request
  // so that the result register fills and the block stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        stall_left = SQUEEZE_CYCLES;
      end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare every gesture beat with the oldest owed gesture.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (gesture_due.size() == 0) begin
        $error("gesture: expected none, got %0d", m_axis_tdata[GEST_W-1:0]);
        mismatch_count++;
      end else begin
        if (m_axis_tdata[GEST_W-1:0] !== gesture_due[0]) begin
          $error("gesture: expected %0d, got %0d", gesture_due[0], m_axis_tdata[GEST_W-1:0]);
          mismatch_count++;
        end
        void'(gesture_due.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned saved_idle;
    int unsigned phase_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed script. Long runs go without idling to keep the run short.
    idle_pct = 10;
    foreach (script[r]) begin
      if (script[r].kind == ROW_WRITE) begin
        finish_pending();
        write_reg(script[r].idx, CFG_W'(script[r].amount));
      end else begin
        saved_idle = idle_pct;
        if (script[r].amount > 1000) idle_pct = 0;
        run_level(script[r].level, script[r].amount, script[r].typed, script[r].g);
        idle_pct = saved_idle;
      end
    end

    // Random phases, each with its own small register setting and idling level.
    // The last phase runs with no idling at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      finish_pending();
      write_reg(REG_FACTORY, CFG_W'($urandom_range(1, 60)));
      write_reg(REG_PROVISION, CFG_W'($urandom_range(1, 60)));
      write_reg(REG_ACTIVATE, CFG_W'($urandom_range(1, 60)));
      write_reg(REG_DEBOUNCE, CFG_W'($urandom_range(0, 8)));
      write_reg(REG_WINDOW, CFG_W'($urandom_range(1, 20)));
      if (p == RANDOM_PHASES - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 5;
          2: idle_pct = 15;
          default: idle_pct = 30;
        endcase
      end
      // hold off the result side early on while samples keep coming
      if (p == 0) squeeze_req = 1'b1;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < TICKS_PER_PHASE) play_random_gesture();
    end

    finish_pending();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
